// ===== hdl/sacl_pkg.sv =====
// Package for the set-associative LRU cache simulator.
// It holds the shared constants, opcode and register codes, and the access result type.
// It has no dependencies.
package sacl_pkg;

    localparam int MAX_SET_BITS_DEF = 8;
    localparam int MAX_WAYS_DEF     = 8;

    localparam int TAG_W      = 31;
    localparam int ADDR_W     = 32;
    localparam int CNT_W      = 32;
    localparam int OPCODE_W   = 2;
    localparam int SET_BITS_W = 4;
    localparam int WAYS_W     = 4;
    localparam int BLOCK_W    = 5;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 104;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [SET_BITS_W-1:0] SET_BITS_RST = 4'd4;
    localparam logic [WAYS_W-1:0]     WAYS_RST     = 4'd1;
    localparam logic [BLOCK_W-1:0]    BLOCK_RST    = 5'd4;

    localparam logic [OPCODE_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_STORE  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_MODIFY = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_IFETCH = 2'd3;

    localparam logic [1:0] REG_SET_BITS = 2'd0;
    localparam logic [1:0] REG_WAYS     = 2'd1;
    localparam logic [1:0] REG_BLOCK    = 2'd2;

    typedef struct packed {
        logic hit;
        logic miss;
        logic evict;
    } acc_result_t;

endpackage

// ===== hdl/set_assoc_cache_lru_sim.sv =====
// Set-associative cache simulator with LRU replacement, the top level.
// The set row of an input word is read from the set memory as the word is taken; a load or
// store updates the row and writes it back once (state ACC1), a modify twice (ACC1 and
// ACC2), and a fetch touches no set row. A new input word is taken only in IDLE or once the
// last result is formed (DONE). Reset is synchronous and active low; a clearing pass
// over all set rows follows, taking no input word. Depends on sacl_pkg, sacl_ram, sacl_access.
module set_assoc_cache_lru_sim #(
    parameter int MAX_SET_BITS = sacl_pkg::MAX_SET_BITS_DEF,
    parameter int MAX_WAYS     = sacl_pkg::MAX_WAYS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // Fields from bit 0: opcode[1:0], address[33:2], zero padding.
    input  logic [sacl_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // Fields from bit 0: hits_now[1:0], misses_now[3:2], evictions_now[4], hit_total[36:5],
    // miss_total[68:37], eviction_total[100:69], zero padding.
    output logic [sacl_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sacl_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [sacl_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [sacl_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    localparam int RW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int TW    = sacl_pkg::TAG_W;
    localparam int LW    = 1 + RW + TW;
    localparam int ROW_W = MAX_WAYS * LW;
    localparam int DEPTH = 1 << MAX_SET_BITS;
    localparam int SBW   = $clog2(MAX_SET_BITS + 1);
    localparam int WCW   = $clog2(MAX_WAYS + 1);
    localparam int CW    = sacl_pkg::CNT_W;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_ACC1  = 5'b00100,
        ST_ACC2  = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [sacl_pkg::SET_BITS_W-1:0] set_bits_reg;
    logic [sacl_pkg::WAYS_W-1:0]     ways_reg;
    logic [sacl_pkg::BLOCK_W-1:0]    block_reg;

    logic [MAX_SET_BITS-1:0] clr_addr_reg;
    logic [CW-1:0]           hit_ctr_reg, hit_ctr_next;
    logic [CW-1:0]           miss_ctr_reg, miss_ctr_next;
    logic [CW-1:0]           evict_ctr_reg, evict_ctr_next;
    logic [1:0]              hits_now_reg, hits_now_next;
    logic [1:0]              misses_now_reg, misses_now_next;
    logic                    evicts_now_reg, evicts_now_next;
    logic                    m_valid_reg, m_valid_next;
    logic [sacl_pkg::M_TDATA_W-1:0] m_data_reg;

    logic [sacl_pkg::OPCODE_W-1:0] op_reg;
    logic [MAX_SET_BITS-1:0]       set_reg;
    logic [TW-1:0]                 tag_reg;
    logic [ROW_W-1:0]              row_reg;

    logic [sacl_pkg::OPCODE_W-1:0] in_op;
    logic [sacl_pkg::ADDR_W-1:0]   in_addr;
    logic [SBW-1:0]                s_eff;
    logic [WCW-1:0]                ways_eff;
    logic [MAX_SET_BITS-1:0]       set_mask;
    logic [MAX_SET_BITS-1:0]       set_next;
    logic [5:0]                    tag_shift;
    logic [TW-1:0]                 tag_next;
    logic                          accept;
    logic                          out_free;
    logic                          cfg_wr;
    logic                          in_acc;

    logic                          ram_we;
    logic [MAX_SET_BITS-1:0]       ram_waddr;
    logic [ROW_W-1:0]              ram_wdata;
    logic [ROW_W-1:0]              ram_rdata;
    logic [ROW_W-1:0]              acc_row_in;
    logic [ROW_W-1:0]              acc_row_out;
    sacl_pkg::acc_result_t         acc_res;

    assign in_op   = s_tdata[sacl_pkg::OPCODE_W-1:0];
    assign in_addr = s_tdata[sacl_pkg::OPCODE_W +: sacl_pkg::ADDR_W];

    always_comb begin
        if (set_bits_reg == '0) begin
            s_eff = SBW'(1);
        end else if (int'(set_bits_reg) > MAX_SET_BITS) begin
            s_eff = SBW'(MAX_SET_BITS);
        end else begin
            s_eff = SBW'(set_bits_reg);
        end
        if (ways_reg == '0) begin
            ways_eff = WCW'(1);
        end else if (int'(ways_reg) > MAX_WAYS) begin
            ways_eff = WCW'(MAX_WAYS);
        end else begin
            ways_eff = WCW'(ways_reg);
        end
    end

    assign set_mask  = ~({MAX_SET_BITS{1'b1}} << s_eff);
    assign set_next  = MAX_SET_BITS'(in_addr >> block_reg) & set_mask;
    assign tag_shift = 6'(block_reg) + 6'(s_eff);
    assign tag_next  = TW'(in_addr >> tag_shift);

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) || ((state_reg == ST_DONE) && out_free);
    assign accept   = s_tvalid && s_tready;
    assign in_acc   = (state_reg == ST_ACC1) || (state_reg == ST_ACC2);

    assign acc_row_in = (state_reg == ST_ACC2) ? row_reg : ram_rdata;

    sacl_access #(
        .MAX_WAYS (MAX_WAYS)
    ) u_access (
        .row_in  (acc_row_in),
        .tag     (tag_reg),
        .ways    (ways_eff),
        .row_out (acc_row_out),
        .res     (acc_res)
    );

    assign ram_we    = (state_reg == ST_CLEAR) || in_acc;
    assign ram_waddr = (state_reg == ST_CLEAR) ? clr_addr_reg : set_reg;
    assign ram_wdata = (state_reg == ST_CLEAR) ? '0 : acc_row_out;

    sacl_ram #(
        .WIDTH (ROW_W),
        .DEPTH (DEPTH)
    ) u_set_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (set_next),
        .rd_data (ram_rdata)
    );

    always_comb begin
        state_next      = state_reg;
        hit_ctr_next    = hit_ctr_reg;
        miss_ctr_next   = miss_ctr_reg;
        evict_ctr_next  = evict_ctr_reg;
        hits_now_next   = hits_now_reg;
        misses_now_next = misses_now_reg;
        evicts_now_next = evicts_now_reg;
        m_valid_next    = m_valid_reg;

        if (in_acc) begin
            hit_ctr_next    = hit_ctr_reg + CW'(acc_res.hit);
            miss_ctr_next   = miss_ctr_reg + CW'(acc_res.miss);
            evict_ctr_next  = evict_ctr_reg + CW'(acc_res.evict);
            hits_now_next   = hits_now_reg + 2'(acc_res.hit);
            misses_now_next = misses_now_reg + 2'(acc_res.miss);
            evicts_now_next = evicts_now_reg | acc_res.evict;
        end
        if (accept) begin
            hits_now_next   = '0;
            misses_now_next = '0;
            evicts_now_next = 1'b0;
        end

        if (m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                if (&clr_addr_reg) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    state_next = (in_op == sacl_pkg::OP_IFETCH) ? ST_DONE : ST_ACC1;
                end
            end
            ST_ACC1: begin
                state_next = (op_reg == sacl_pkg::OP_MODIFY) ? ST_ACC2 : ST_DONE;
            end
            ST_ACC2: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (accept) begin
                        state_next = (in_op == sacl_pkg::OP_IFETCH) ? ST_DONE : ST_ACC1;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            set_bits_reg   <= sacl_pkg::SET_BITS_RST;
            ways_reg       <= sacl_pkg::WAYS_RST;
            block_reg      <= sacl_pkg::BLOCK_RST;
            hit_ctr_reg    <= '0;
            miss_ctr_reg   <= '0;
            evict_ctr_reg  <= '0;
            hits_now_reg   <= '0;
            misses_now_reg <= '0;
            evicts_now_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            hit_ctr_reg    <= hit_ctr_next;
            miss_ctr_reg   <= miss_ctr_next;
            evict_ctr_reg  <= evict_ctr_next;
            hits_now_reg   <= hits_now_next;
            misses_now_reg <= misses_now_next;
            evicts_now_reg <= evicts_now_next;
            m_valid_reg    <= m_valid_next;
            if (state_reg == ST_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + MAX_SET_BITS'(1);
            end
            if (cfg_wr) begin
                unique case (paddr[3:2])
                    sacl_pkg::REG_SET_BITS: set_bits_reg <= pwdata[sacl_pkg::SET_BITS_W-1:0];
                    sacl_pkg::REG_WAYS:     ways_reg     <= pwdata[sacl_pkg::WAYS_W-1:0];
                    sacl_pkg::REG_BLOCK:    block_reg    <= pwdata[sacl_pkg::BLOCK_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg  <= in_op;
            set_reg <= set_next;
            tag_reg <= tag_next;
        end
        if (state_reg == ST_ACC1) begin
            row_reg <= acc_row_out;
        end
        if ((state_reg == ST_DONE) && out_free) begin
            m_data_reg <= {3'b000, evict_ctr_reg, miss_ctr_reg, hit_ctr_reg,
                           evicts_now_reg, misses_now_reg, hits_now_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign pready   = 1'b1;

    always_comb begin
        unique case (paddr[3:2])
            sacl_pkg::REG_SET_BITS: prdata = sacl_pkg::APB_DATA_W'(set_bits_reg);
            sacl_pkg::REG_WAYS:     prdata = sacl_pkg::APB_DATA_W'(ways_reg);
            sacl_pkg::REG_BLOCK:    prdata = sacl_pkg::APB_DATA_W'(block_reg);
            default:                prdata = '0;
        endcase
    end

`ifndef SYNTHESIS
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_tready)
        else $error("input word taken during the clearing pass");

    a_single_access: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_ACC1) && (op_reg != sacl_pkg::OP_MODIFY)) |=>
        (state_reg == ST_DONE))
        else $error("load or store made more than one access");

    a_one_count_per_access: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |=> (CW'(hit_ctr_reg + miss_ctr_reg) ==
                    CW'($past(hit_ctr_reg + miss_ctr_reg) + CW'(1))))
        else $error("an access did not count exactly one hit or miss");

    a_result_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((3'(m_tdata[1:0]) + 3'(m_tdata[3:2])) <= 3'd2) &&
                     (!m_tdata[4] || (m_tdata[3:2] != 2'd0)))
        else $error("result word counts are inconsistent");
`endif

endmodule

// ===== hdl/sacl_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// It depends on nothing.
module sacl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/sacl_access.sv =====
// Lookup and LRU update of one cache set row: hit search, fill, victim choice, rank aging.
// It depends on sacl_pkg.
module sacl_access #(
    parameter int MAX_WAYS = sacl_pkg::MAX_WAYS_DEF
) (
    input  logic [MAX_WAYS*(2+sacl_pkg::TAG_W+((MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1))
                  -MAX_WAYS-1:0]          row_in,
    input  logic [sacl_pkg::TAG_W-1:0]    tag,
    input  logic [$clog2(MAX_WAYS+1)-1:0] ways,
    output logic [MAX_WAYS*(2+sacl_pkg::TAG_W+((MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1))
                  -MAX_WAYS-1:0]          row_out,
    output sacl_pkg::acc_result_t         res
);

    localparam int RW  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int TW  = sacl_pkg::TAG_W;
    localparam int LW  = 1 + RW + TW;
    localparam int WCW = $clog2(MAX_WAYS + 1);

    logic          v      [MAX_WAYS];
    logic [RW-1:0] r      [MAX_WAYS];
    logic [TW-1:0] t      [MAX_WAYS];
    logic          in_use [MAX_WAYS];
    logic          hit_v  [MAX_WAYS];
    logic          inv_v  [MAX_WAYS];
    logic          any_hit;
    logic          any_inv;
    logic [RW-1:0] hit_way;
    logic [RW-1:0] inv_way;
    logic [RW-1:0] vic_way;
    logic [RW-1:0] best;
    logic [RW-1:0] pick;
    logic [RW:0]   old_rank;

    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            v[w]      = row_in[w*LW];
            r[w]      = row_in[w*LW+1 +: RW];
            t[w]      = row_in[w*LW+1+RW +: TW];
            in_use[w] = ways > WCW'(w);
            hit_v[w]  = in_use[w] && v[w] && (t[w] == tag);
            inv_v[w]  = in_use[w] && !v[w];
        end

        any_hit = 1'b0;
        any_inv = 1'b0;
        hit_way = '0;
        inv_way = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (hit_v[w]) begin
                any_hit = 1'b1;
                hit_way = RW'(w);
            end
            if (inv_v[w]) begin
                any_inv = 1'b1;
                inv_way = RW'(w);
            end
        end

        best    = r[0];
        vic_way = '0;
        for (int w = 1; w < MAX_WAYS; w++) begin
            if (in_use[w] && (r[w] > best)) begin
                best    = r[w];
                vic_way = RW'(w);
            end
        end

        if (any_hit) begin
            pick     = hit_way;
            old_rank = {1'b0, r[hit_way]};
        end else if (any_inv) begin
            pick     = inv_way;
            old_rank = (RW+1)'(MAX_WAYS);
        end else begin
            pick     = vic_way;
            old_rank = {1'b0, best};
        end

        for (int w = 0; w < MAX_WAYS; w++) begin
            if (RW'(w) == pick) begin
                row_out[w*LW]            = 1'b1;
                row_out[w*LW+1 +: RW]    = '0;
                row_out[w*LW+1+RW +: TW] = any_hit ? t[w] : tag;
            end else begin
                row_out[w*LW]            = v[w];
                row_out[w*LW+1+RW +: TW] = t[w];
                if (in_use[w] && v[w] && ({1'b0, r[w]} < old_rank) &&
                    (r[w] < RW'(MAX_WAYS - 1))) begin
                    row_out[w*LW+1 +: RW] = r[w] + RW'(1);
                end else begin
                    row_out[w*LW+1 +: RW] = r[w];
                end
            end
        end

        res.hit   = any_hit;
        res.miss  = !any_hit;
        res.evict = !any_hit && !any_inv;
    end

endmodule
